/* rtl/fhd_pkg.sv */
// Shared constants for the frame header deframer: field widths,
// register indexes and register reset values. No dependencies.
`default_nettype none

package fhd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned MASK_W       = 64;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned HDR_COUNT_W  = 4;

    // header layout: version, op, four id bytes, four length bytes
    localparam logic [HDR_COUNT_W-1:0] HDR_BYTES     = 4'd10;
    localparam logic [HDR_COUNT_W-1:0] HDR_POS_VER   = 4'd0;
    localparam logic [HDR_COUNT_W-1:0] HDR_POS_OP    = 4'd1;
    localparam logic [HDR_COUNT_W-1:0] HDR_POS_SID_END = 4'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_OP_MASK    = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_EXPECTED_VERSION   = 8'd1;
    localparam logic [WORD_W-1:0] RST_MAX_PAYLOAD_LENGTH = 32'd65536;
    localparam logic [MASK_W-1:0] RST_ALLOWED_OP_MASK    = 64'd8191;

    // result kind and status codes
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // input command codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

endpackage

`default_nettype wire

/* rtl/fhd_in_if.sv */
// Input channel of the frame header deframer: valid/ready plus one stream item.
// Depends on fhd_pkg.
`default_nettype none

interface fhd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [fhd_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/fhd_out_if.sv */
// Result channel of the frame header deframer: valid/ready plus one result item.
// Depends on fhd_pkg.
`default_nettype none

interface fhd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic                        status;
    logic [fhd_pkg::BYTE_W-1:0]  op_code;
    logic [fhd_pkg::WORD_W-1:0]  stream_ident;
    logic [fhd_pkg::WORD_W-1:0]  payload_length;
    logic [fhd_pkg::BYTE_W-1:0]  payload_byte;
    logic                        frame_last;

    modport source (output valid, output kind, output status, output op_code,
                    output stream_ident, output payload_length, output payload_byte,
                    output frame_last, input ready);
    modport sink   (input valid, input kind, input status, input op_code,
                    input stream_ident, input payload_length, input payload_byte,
                    input frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/frame_header_deframer.sv */
// Frame header deframer top level: header collection, header check, payload pass.
// Depends on fhd_pkg, fhd_in_if and fhd_out_if.
`default_nettype none

// Channel     Dir   Handshake          Item
// ---------   ---   ----------------   ------------------------------------------
// in_ch       in    valid/ready        command, data_byte
// out_ch      out   valid/ready        kind, status, op_code, stream_ident,
//                                      payload_length, payload_byte, frame_last
// cfg         in    cfg_we (no wait)   cfg_index, cfg_data
//
// One item per cycle: each item is decoded in the cycle it is accepted and its
// result, if any, lands in the output register on the same edge.
// in_ch.ready is high while the output register is empty or being drained,
// so a full output register stalls input only while out_ch.ready is low.
// rst_n (async, active low) clears parser state, the output valid and the
// configuration registers to their defaults.

module frame_header_deframer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    fhd_in_if.sink                                  in_ch,
    fhd_out_if.source                               out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [fhd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fhd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_DISCARD = 2'd2
    } mode_t;

    // configuration
    logic [fhd_pkg::BYTE_W-1:0] exp_version_reg;
    logic [fhd_pkg::WORD_W-1:0] max_length_reg;
    logic [fhd_pkg::MASK_W-1:0] op_mask_reg;

    // parser state
    mode_t                           mode_reg,     mode_next;
    logic [fhd_pkg::HDR_COUNT_W-1:0] hdr_cnt_reg,  hdr_cnt_next;
    logic [fhd_pkg::BYTE_W-1:0]      version_reg,  version_next;
    logic [fhd_pkg::BYTE_W-1:0]      op_reg,       op_next;
    logic [fhd_pkg::WORD_W-1:0]      stream_reg,   stream_next;
    logic [fhd_pkg::WORD_W-1:0]      length_reg,   length_next;
    logic [fhd_pkg::WORD_W-1:0]      remain_reg,   remain_next;

    // output register
    logic                            out_valid_reg;
    logic                            res_valid_next;
    logic                            kind_reg,     kind_next;
    logic                            status_reg,   status_next;
    logic [fhd_pkg::BYTE_W-1:0]      op_code_reg,  op_code_next;
    logic [fhd_pkg::WORD_W-1:0]      sid_reg,      sid_next;
    logic [fhd_pkg::WORD_W-1:0]      plen_reg,     plen_next;
    logic [fhd_pkg::BYTE_W-1:0]      pbyte_reg,    pbyte_next;
    logic                            last_reg,     last_next;

    logic                            accept;
    logic [fhd_pkg::HDR_COUNT_W-1:0] cnt_inc;
    logic                            hdr_ok;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cnt_inc     = hdr_cnt_reg + 1'b1;

    // header check, used on the tenth byte: version and op are already held,
    // the length takes its last byte from the item taken this cycle
    assign hdr_ok = (version_reg == exp_version_reg)
                 && (op_reg[fhd_pkg::BYTE_W-1:6] == '0)
                 && op_mask_reg[op_reg[5:0]]
                 && ({length_reg[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], in_ch.data_byte}
                     <= max_length_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        version_next   = version_reg;
        op_next        = op_reg;
        stream_next    = stream_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        res_valid_next = 1'b0;
        kind_next      = fhd_pkg::KIND_HEADER;
        status_next    = fhd_pkg::STATUS_OK;
        op_code_next   = '0;
        sid_next       = '0;
        plen_next      = '0;
        pbyte_next     = '0;
        last_next      = 1'b0;

        if (in_ch.command == fhd_pkg::CMD_RESTART)
        begin
            mode_next    = MODE_HEADER;
            hdr_cnt_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_DISCARD:
                begin
                    // dropped until a restart
                end
                MODE_PAYLOAD:
                begin
                    res_valid_next = 1'b1;
                    kind_next      = fhd_pkg::KIND_PAYLOAD;
                    pbyte_next     = in_ch.data_byte;
                    if (remain_reg <= fhd_pkg::WORD_W'(1))
                    begin
                        last_next    = 1'b1;
                        remain_next  = '0;
                        mode_next    = MODE_HEADER;
                        hdr_cnt_next = '0;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
                default:
                begin
                    // header collection, also taken for the unused mode code
                    mode_next = MODE_HEADER;
                    if (hdr_cnt_reg == fhd_pkg::HDR_POS_VER)
                        version_next = in_ch.data_byte;
                    else if (hdr_cnt_reg == fhd_pkg::HDR_POS_OP)
                        op_next = in_ch.data_byte;
                    else if (hdr_cnt_reg <= fhd_pkg::HDR_POS_SID_END)
                        stream_next = {stream_reg[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0],
                                       in_ch.data_byte};
                    else
                        length_next = {length_reg[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0],
                                       in_ch.data_byte};

                    hdr_cnt_next = cnt_inc;
                    if (cnt_inc >= fhd_pkg::HDR_BYTES)
                    begin
                        hdr_cnt_next   = '0;
                        res_valid_next = 1'b1;
                        kind_next      = fhd_pkg::KIND_HEADER;
                        status_next    = hdr_ok ? fhd_pkg::STATUS_OK
                                                : fhd_pkg::STATUS_INVALID;
                        op_code_next   = op_next;
                        sid_next       = stream_next;
                        plen_next      = length_next;
                        if (!hdr_ok)
                        begin
                            mode_next = MODE_DISCARD;
                        end
                        else if (length_next == '0)
                        begin
                            last_next = 1'b1;
                        end
                        else
                        begin
                            remain_next = length_next;
                            mode_next   = MODE_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= fhd_pkg::RST_EXPECTED_VERSION;
            max_length_reg  <= fhd_pkg::RST_MAX_PAYLOAD_LENGTH;
            op_mask_reg     <= fhd_pkg::RST_ALLOWED_OP_MASK;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fhd_pkg::CFG_EXPECTED_VERSION)
                exp_version_reg <= cfg_data[fhd_pkg::BYTE_W-1:0];
            else if (cfg_index == fhd_pkg::CFG_MAX_PAYLOAD_LENGTH)
                max_length_reg <= cfg_data[fhd_pkg::WORD_W-1:0];
            else if (cfg_index == fhd_pkg::CFG_ALLOWED_OP_MASK)
                op_mask_reg <= cfg_data[fhd_pkg::MASK_W-1:0];
        end
    end

    // parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HEADER;
            hdr_cnt_reg   <= '0;
            version_reg   <= '0;
            op_reg        <= '0;
            stream_reg    <= '0;
            length_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg    <= mode_next;
                hdr_cnt_reg <= hdr_cnt_next;
                version_reg <= version_next;
                op_reg      <= op_next;
                stream_reg  <= stream_next;
                length_reg  <= length_next;
                remain_reg  <= remain_next;
            end
            if (in_ch.ready)
                out_valid_reg <= accept && res_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (accept && res_valid_next)
        begin
            kind_reg    <= kind_next;
            status_reg  <= status_next;
            op_code_reg <= op_code_next;
            sid_reg     <= sid_next;
            plen_reg    <= plen_next;
            pbyte_reg   <= pbyte_next;
            last_reg    <= last_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.kind           = kind_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.op_code        = op_code_reg;
    assign out_ch.stream_ident   = sid_reg;
    assign out_ch.payload_length = plen_reg;
    assign out_ch.payload_byte   = pbyte_reg;
    assign out_ch.frame_last     = last_reg;

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for frame_header_deframer: sends byte-stream items, predicts the header
// and payload results, and checks each result item as the block hands it out.
// Depends on fhd_pkg, fhd_in_if, fhd_out_if and the frame_header_deframer RTL.

module tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SHORT_PAYLOAD = 12;  // longer payloads are cut by a restart
    localparam int unsigned FRAMES_PER_CFG = 8;  // frames between register changes
    localparam int unsigned SETTLE_CYCLES = 4;   // result lands on the edge that takes the item

    // index past the register list; a write there must change nothing
    localparam logic [fhd_pkg::CFG_INDEX_W-1:0] CFG_NO_REGISTER = 2'd3;

    typedef enum logic [1:0] {PARSE_HEADER, PARSE_PAYLOAD, PARSE_DISCARD} parse_mode_t;

    typedef struct packed {
        logic                        kind;
        logic                        status;
        logic [fhd_pkg::BYTE_W-1:0]  op_code;
        logic [fhd_pkg::WORD_W-1:0]  stream_ident;
        logic [fhd_pkg::WORD_W-1:0]  payload_length;
        logic [fhd_pkg::BYTE_W-1:0]  payload_byte;
        logic                        frame_last;
    } frame_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [fhd_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [fhd_pkg::CFG_DATA_W-1:0]   cfg_data;

    fhd_in_if  in_ch();
    fhd_out_if out_ch();

    frame_header_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers, starting at their reset values.
    logic [fhd_pkg::BYTE_W-1:0]  want_version = fhd_pkg::RST_EXPECTED_VERSION;
    logic [fhd_pkg::WORD_W-1:0]  max_length   = fhd_pkg::RST_MAX_PAYLOAD_LENGTH;
    logic [fhd_pkg::MASK_W-1:0]  op_mask      = fhd_pkg::RST_ALLOWED_OP_MASK;

    // Predictor copy of the parser state.
    parse_mode_t                      mode       = PARSE_HEADER;
    logic [fhd_pkg::HDR_COUNT_W-1:0]  hdr_count  = '0;
    logic [fhd_pkg::BYTE_W-1:0]       ver_seen   = '0;
    logic [fhd_pkg::BYTE_W-1:0]       op_seen    = '0;
    logic [fhd_pkg::WORD_W-1:0]       sid_shift  = '0;
    logic [fhd_pkg::WORD_W-1:0]       len_shift  = '0;
    logic [fhd_pkg::WORD_W-1:0]       bytes_left = '0;

    frame_result_t pending_results[$];

    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned stream_items = 0;  // stream-byte items sent, restarts left out
    int unsigned gap_pct      = 0;  // sender idles this many cycles in a hundred
    int unsigned stall_pct    = 0;  // receiver stalls this many cycles in a hundred

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: ready changes on the falling edge only.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Predictor: one accepted item in, at most one expected result out.
    // ------------------------------------------------------------------
    task automatic deframe_byte(input logic cmd, input logic [fhd_pkg::BYTE_W-1:0] b,
                                output bit produced, output frame_result_t res);
        bit hdr_ok;
        produced = 1'b0;
        res      = '0;

        // restart wins in every mode; the data byte is ignored
        if (cmd == fhd_pkg::CMD_RESTART)
        begin
            mode      = PARSE_HEADER;
            hdr_count = '0;
            return;
        end

        // after a bad header everything is dropped until a restart
        if (mode == PARSE_DISCARD)
            return;

        if (mode == PARSE_PAYLOAD)
        begin
            produced         = 1'b1;
            res.kind         = fhd_pkg::KIND_PAYLOAD;
            res.payload_byte = b;
            if (bytes_left <= 1)
            begin
                res.frame_last = 1'b1;
                bytes_left     = '0;
                mode           = PARSE_HEADER;
                hdr_count      = '0;
            end
            else
                bytes_left--;
            return;
        end

        // header collection: id and length arrive most significant byte first
        if (hdr_count == fhd_pkg::HDR_POS_VER)
            ver_seen = b;
        else if (hdr_count == fhd_pkg::HDR_POS_OP)
            op_seen = b;
        else if (hdr_count <= fhd_pkg::HDR_POS_SID_END)
            sid_shift = {sid_shift[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
        else
            len_shift = {len_shift[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
        hdr_count++;
        if (hdr_count != fhd_pkg::HDR_BYTES)
            return;

        // tenth byte: check the header against the registers as they stand now
        hdr_count = '0;
        hdr_ok = (ver_seen == want_version) && (op_seen < fhd_pkg::MASK_W)
                 && op_mask[op_seen[5:0]] && (len_shift <= max_length);
        produced           = 1'b1;
        res.kind           = fhd_pkg::KIND_HEADER;
        res.status         = hdr_ok ? fhd_pkg::STATUS_OK : fhd_pkg::STATUS_INVALID;
        res.op_code        = op_seen;
        res.stream_ident   = sid_shift;
        res.payload_length = len_shift;
        if (!hdr_ok)
            mode = PARSE_DISCARD;
        else if (len_shift == '0)
            res.frame_last = 1'b1;  // empty frame ends on its header
        else
        begin
            bytes_left = len_shift;
            mode       = PARSE_PAYLOAD;
        end
    endtask

    task automatic report_field(input string name, input logic [fhd_pkg::WORD_W-1:0] want,
                                input logic [fhd_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. The result check
    // runs before the prediction so a stray result is never matched against
    // the item taken on the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        frame_result_t seen;
        frame_result_t want;
        bit            produced;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen.kind           = out_ch.kind;
                seen.status         = out_ch.status;
                seen.op_code        = out_ch.op_code;
                seen.stream_ident   = out_ch.stream_ident;
                seen.payload_length = out_ch.payload_length;
                seen.payload_byte   = out_ch.payload_byte;
                seen.frame_last     = out_ch.frame_last;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none pending: expected nothing, got %h",
                             $time, seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    report_field("kind", want.kind, seen.kind);
                    report_field("status", want.status, seen.status);
                    report_field("op_code", want.op_code, seen.op_code);
                    report_field("stream_ident", want.stream_ident, seen.stream_ident);
                    report_field("payload_length", want.payload_length,
                                 seen.payload_length);
                    report_field("payload_byte", want.payload_byte, seen.payload_byte);
                    report_field("frame_last", want.frame_last, seen.frame_last);
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                deframe_byte(in_ch.command, in_ch.data_byte, produced, want);
                if (produced)
                    pending_results.push_back(want);
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    fhd_pkg::CFG_EXPECTED_VERSION:
                        want_version = cfg_data[fhd_pkg::BYTE_W-1:0];
                    fhd_pkg::CFG_MAX_PAYLOAD_LENGTH:
                        max_length   = cfg_data[fhd_pkg::WORD_W-1:0];
                    fhd_pkg::CFG_ALLOWED_OP_MASK:
                        op_mask      = cfg_data[fhd_pkg::MASK_W-1:0];
                    default: ;  // no register behind this index
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one item, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_item(input logic cmd, input logic [fhd_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (cmd == fhd_pkg::CMD_BYTE)
            stream_items++;
        @(negedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write.
    task automatic write_reg(input logic [fhd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fhd_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [fhd_pkg::BYTE_W-1:0] ver,
                              input logic [fhd_pkg::WORD_W-1:0] max_len,
                              input logic [fhd_pkg::MASK_W-1:0] mask);
        write_reg(fhd_pkg::CFG_EXPECTED_VERSION, fhd_pkg::CFG_DATA_W'(ver));
        write_reg(fhd_pkg::CFG_MAX_PAYLOAD_LENGTH, fhd_pkg::CFG_DATA_W'(max_len));
        write_reg(fhd_pkg::CFG_ALLOWED_OP_MASK, mask);
        cfg_we <= 1'b0;
    endtask

    // Idle the input and wait until every expected result is out. Header bytes
    // and dropped bytes give no result, so allow a few cycles on top.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_header(input logic [fhd_pkg::BYTE_W-1:0] ver,
                               input logic [fhd_pkg::BYTE_W-1:0] op,
                               input logic [fhd_pkg::WORD_W-1:0] sid,
                               input logic [fhd_pkg::WORD_W-1:0] plen);
        send_item(fhd_pkg::CMD_BYTE, ver);
        send_item(fhd_pkg::CMD_BYTE, op);
        for (int i = 3; i >= 0; i--)
            send_item(fhd_pkg::CMD_BYTE, sid[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            send_item(fhd_pkg::CMD_BYTE, plen[8*i +: 8]);
    endtask

    task automatic send_payload(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_item(fhd_pkg::CMD_BYTE, fhd_pkg::BYTE_W'($urandom_range(255)));
    endtask

    function automatic logic [fhd_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Random op whose mask bit is set; any byte when the mask is empty.
    function automatic logic [fhd_pkg::BYTE_W-1:0] pick_allowed_op();
        int unsigned start;
        int unsigned n;
        start = $urandom_range(fhd_pkg::MASK_W - 1);
        for (int unsigned i = 0; i < fhd_pkg::MASK_W; i++)
        begin
            n = (start + i) % fhd_pkg::MASK_W;
            if (op_mask[n])
                return fhd_pkg::BYTE_W'(n);
        end
        return fhd_pkg::BYTE_W'($urandom_range(255));
    endfunction

    task automatic pick_random_config();
        logic [fhd_pkg::BYTE_W-1:0] ver;
        logic [fhd_pkg::WORD_W-1:0] max_len;
        logic [fhd_pkg::MASK_W-1:0] mask;
        case ($urandom_range(3))
            0:       ver = '0;
            1:       ver = '1;
            2:       ver = fhd_pkg::RST_EXPECTED_VERSION;
            default: ver = fhd_pkg::BYTE_W'($urandom_range(255));
        endcase
        case ($urandom_range(4))
            0:       max_len = '0;
            1:       max_len = '1;
            2:       max_len = fhd_pkg::RST_MAX_PAYLOAD_LENGTH;
            3:       max_len = $urandom_range(20);
            default: max_len = $urandom();
        endcase
        case ($urandom_range(4))
            0:       mask = '0;
            1:       mask = '1;
            2:       mask = fhd_pkg::RST_ALLOWED_OP_MASK;
            3:       mask = 64'h1 << (fhd_pkg::MASK_W - 1);
            default: mask = {$urandom(), $urandom()};
        endcase
        set_config(ver, max_len, mask);
    endtask

    // One frame-sized chunk of traffic. Mostly headers that pass the current
    // registers with short payloads; the rest are bad headers, cut headers
    // and raw noise.
    task automatic send_random_frame();
        int unsigned                pick;
        int unsigned                n;
        logic [fhd_pkg::BYTE_W-1:0] ver;
        logic [fhd_pkg::BYTE_W-1:0] op;
        logic [fhd_pkg::WORD_W-1:0] sid;
        logic [fhd_pkg::WORD_W-1:0] plen;

        // get back to a clean header start if the last chunk left the parser elsewhere
        if (mode != PARSE_HEADER || hdr_count != '0)
            send_item(fhd_pkg::CMD_RESTART, fhd_pkg::BYTE_W'($urandom_range(255)));

        pick = $urandom_range(99);
        ver  = want_version;
        op   = pick_allowed_op();
        sid  = rand_word();
        if (max_length == '0 || $urandom_range(9) == 0)
            plen = max_length;
        else
            plen = $urandom_range((max_length < 6) ? max_length : 6);

        if (pick < 70)
        begin
            send_header(ver, op, sid, plen);
            if (plen > SHORT_PAYLOAD)
            begin
                // huge payload: a few bytes, then abandon it
                send_payload($urandom_range(3));
                send_item(fhd_pkg::CMD_RESTART, fhd_pkg::BYTE_W'($urandom_range(255)));
            end
            else if (plen > 1 && $urandom_range(9) == 0)
            begin
                send_payload($urandom_range(1, plen - 1));
                send_item(fhd_pkg::CMD_RESTART, fhd_pkg::BYTE_W'($urandom_range(255)));
            end
            else
                send_payload(plen);
        end
        else if (pick < 85)
        begin
            // break one header check; with an empty op mask the op check fails as well
            case ($urandom_range(2))
                0: ver = ver ^ (8'd1 << $urandom_range(7));
                1: op  = fhd_pkg::BYTE_W'($urandom_range(64, 255));
                default:
                    if (max_length != '1)
                        plen = $urandom_range(1) ? max_length + 1 : '1;
                    else
                        ver = ~ver;
            endcase
            send_header(ver, op, sid, plen);
            send_payload($urandom_range(3));  // dropped bytes
        end
        else if (pick < 93)
        begin
            n = $urandom_range(fhd_pkg::HDR_BYTES - 1);
            send_payload(n);
            send_item(fhd_pkg::CMD_RESTART, fhd_pkg::BYTE_W'($urandom_range(255)));
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (int unsigned i = 0; i < n; i++)
                send_item(1'($urandom_range(1)), fhd_pkg::BYTE_W'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All-ones registers and all-ones fields, highest allowed op, then a
    // restart in the middle of the payload.
    task automatic test_field_extremes();
        set_config('1, '1, '1);
        send_header('1, 8'd63, '1, '1);
        send_item(fhd_pkg::CMD_BYTE, 8'h00);
        send_item(fhd_pkg::CMD_BYTE, 8'hFF);
        send_item(fhd_pkg::CMD_RESTART, 8'h00);
    endtask

    // A write past the register list must not alias onto a real register;
    // the empty frame that follows only passes if the version and op mask are untouched.
    task automatic test_unused_index();
        drain_results();
        write_reg(CFG_NO_REGISTER, '0);
        cfg_we <= 1'b0;
        send_header('1, 8'd0, '0, '0);
    endtask

    // Op 64 is out of the mask range: header invalid, following bytes
    // dropped, a restart with a nonzero data byte, then a header cut short.
    task automatic test_restart_and_discard();
        drain_results();
        set_config(fhd_pkg::RST_EXPECTED_VERSION, fhd_pkg::RST_MAX_PAYLOAD_LENGTH,
                   fhd_pkg::RST_ALLOWED_OP_MASK);
        send_header(fhd_pkg::RST_EXPECTED_VERSION, 8'd64, 32'h0123_4567, 32'd1);
        send_item(fhd_pkg::CMD_BYTE, 8'hA5);
        send_item(fhd_pkg::CMD_RESTART, 8'hFF);
        send_item(fhd_pkg::CMD_BYTE, fhd_pkg::RST_EXPECTED_VERSION);
        send_item(fhd_pkg::CMD_BYTE, 8'd12);
        send_item(fhd_pkg::CMD_RESTART, 8'h00);
    endtask

    // Random frames; registers change every few frames while the block is idle.
    task automatic test_random_traffic(input int unsigned quota);
        int unsigned goal;
        int unsigned frames;
        goal   = stream_items + quota;
        frames = 0;
        while (stream_items < goal)
        begin
            if (frames != 0 && frames % FRAMES_PER_CFG == 0)
            begin
                drain_results();
                pick_random_config();
            end
            send_random_frame();
            frames++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = fhd_pkg::CMD_BYTE;
        in_ch.data_byte = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_unused_index();
        test_restart_and_discard();
        drain_results();

        // sender gappy, receiver stalling hard
        gap_pct   = 25;
        stall_pct = 64;
        test_random_traffic(185);
        // and the other way round
        gap_pct   = 64;
        stall_pct = 25;
        test_random_traffic(185);
        // back to back
        gap_pct   = 0;
        stall_pct = 0;
        test_random_traffic(180);

        drain_results();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fhd_pkg.sv
rtl/fhd_in_if.sv
rtl/fhd_out_if.sv
rtl/frame_header_deframer.sv
bench/tb.sv
